### design/arcp_pkg.sv
// shared types, constants and helpers for the ascii register command parser
// no dependencies; used by every module of the block
package arcp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_OP  = 3'd1;
  localparam logic [2:0] ST_COMMA1  = 3'd2;
  localparam logic [2:0] ST_COMMA2  = 3'd3;
  localparam logic [2:0] ST_BAD_HEX = 3'd4;

  localparam logic [2:0] POS_OP      = 3'd0;
  localparam logic [2:0] POS_COMMA1  = 3'd1;
  localparam logic [2:0] POS_ADDR_HI = 3'd2;
  localparam logic [2:0] POS_ADDR_LO = 3'd3;
  localparam logic [2:0] POS_COMMA2  = 3'd4;
  localparam logic [2:0] POS_DATA_HI = 3'd5;
  localparam logic [2:0] POS_DATA_LO = 3'd6;
  localparam logic [2:0] POS_LAST    = 3'd7;

  localparam logic [7:0] CH_W_UP = 8'h57;
  localparam logic [7:0] CH_W_LO = 8'h77;
  localparam logic [7:0] CH_R_UP = 8'h52;
  localparam logic [7:0] CH_R_LO = 8'h72;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic       is_read;
    logic [7:0] reg_address;
    logic [7:0] reg_data;
    logic [2:0] status;
  } out_item_t;

  // frame state captured at the end byte, before the missing positions are filled
  typedef struct packed {
    logic       op_is_read;
    logic [7:0] address;
    logic [7:0] data;
    logic [2:0] status;
    logic [2:0] position;
  } frame_rec_t;

  // {valid, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      r = {1'b1, 4'(c - 8'd48)};
    end else if (c >= 8'd65 && c <= 8'd70) begin
      r = {1'b1, 4'(c - 8'd55)};
    end else if (c >= 8'd97 && c <= 8'd102) begin
      r = {1'b1, 4'(c - 8'd87)};
    end
    return r;
  endfunction

endpackage

### design/arcp_front.sv
// front part: takes characters, classifies them and builds the frame state
// depends on arcp_pkg; hands finished frames to arcp_queue
module arcp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  arcp_pkg::in_item_t    char_in,
  output logic                  rec_push,
  output arcp_pkg::frame_rec_t  rec
);

  logic [2:0] char_position;
  logic       op_is_read;
  logic [7:0] address_acc;
  logic [7:0] data_acc;
  logic [2:0] status_acc;
  logic       digit_live;

  logic [2:0] char_position_next;
  logic       op_is_read_next;
  logic [7:0] address_acc_next;
  logic [7:0] data_acc_next;
  logic [2:0] status_acc_next;
  logic       digit_live_next;
  logic [4:0] hex;
  logic [7:0] c;

  assign c   = char_in.char_byte;
  assign hex = arcp_pkg::hex_decode(c);

  always_comb begin
    op_is_read_next  = op_is_read;
    address_acc_next = address_acc;
    data_acc_next    = data_acc;
    status_acc_next  = status_acc;
    digit_live_next  = digit_live;
    case (char_position)
      arcp_pkg::POS_OP: begin
        if (c == arcp_pkg::CH_W_UP || c == arcp_pkg::CH_W_LO) begin
          op_is_read_next = 1'b0;
        end else if (c == arcp_pkg::CH_R_UP || c == arcp_pkg::CH_R_LO) begin
          op_is_read_next = 1'b1;
        end else begin
          status_acc_next = arcp_pkg::ST_BAD_OP;
        end
      end
      arcp_pkg::POS_COMMA1: begin
        if (status_acc == arcp_pkg::ST_OK && c != arcp_pkg::CH_COMMA)
          status_acc_next = arcp_pkg::ST_COMMA1;
      end
      arcp_pkg::POS_ADDR_HI: begin
        digit_live_next = (status_acc == arcp_pkg::ST_OK);
        if (status_acc == arcp_pkg::ST_OK) begin
          address_acc_next = {hex[3:0], 4'd0};
          if (!hex[4]) status_acc_next = arcp_pkg::ST_BAD_HEX;
        end
      end
      arcp_pkg::POS_ADDR_LO: begin
        if (digit_live) begin
          address_acc_next = address_acc | {4'd0, hex[3:0]};
          if (!hex[4] && status_acc == arcp_pkg::ST_OK) status_acc_next = arcp_pkg::ST_BAD_HEX;
        end
        digit_live_next = 1'b0;
      end
      arcp_pkg::POS_COMMA2: begin
        if (status_acc == arcp_pkg::ST_OK && c != arcp_pkg::CH_COMMA)
          status_acc_next = arcp_pkg::ST_COMMA2;
      end
      arcp_pkg::POS_DATA_HI: begin
        digit_live_next = (status_acc == arcp_pkg::ST_OK);
        if (status_acc == arcp_pkg::ST_OK) begin
          data_acc_next = {hex[3:0], 4'd0};
          if (!hex[4]) status_acc_next = arcp_pkg::ST_BAD_HEX;
        end
      end
      arcp_pkg::POS_DATA_LO: begin
        if (digit_live) begin
          data_acc_next = data_acc | {4'd0, hex[3:0]};
          if (!hex[4] && status_acc == arcp_pkg::ST_OK) status_acc_next = arcp_pkg::ST_BAD_HEX;
        end
        digit_live_next = 1'b0;
      end
      default: begin
      end
    endcase
    char_position_next = (char_position == arcp_pkg::POS_LAST) ? char_position
                                                                : char_position + 3'd1;
  end

  assign rec_push        = accept && char_in.frame_end;
  assign rec.op_is_read  = op_is_read_next;
  assign rec.address     = address_acc_next;
  assign rec.data        = data_acc_next;
  assign rec.status      = status_acc_next;
  assign rec.position    = char_position_next;

  always_ff @(posedge clk) begin
    if (rst || rec_push) begin
      char_position <= arcp_pkg::POS_OP;
      op_is_read    <= 1'b0;
      address_acc   <= 8'd0;
      data_acc      <= 8'd0;
      status_acc    <= arcp_pkg::ST_OK;
      digit_live    <= 1'b0;
    end else if (accept) begin
      char_position <= char_position_next;
      op_is_read    <= op_is_read_next;
      address_acc   <= address_acc_next;
      data_acc      <= data_acc_next;
      status_acc    <= status_acc_next;
      digit_live    <= digit_live_next;
    end
  end

endmodule

### design/arcp_queue.sv
// short first-in first-out queue of finished frames between front and back
// depends on arcp_pkg for the frame record type
module arcp_queue #(
  parameter int DEPTH = arcp_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  arcp_pkg::frame_rec_t  wr_data,
  output logic                  full,
  input  logic                  rd_en,
  output arcp_pkg::frame_rec_t  rd_data,
  output logic                  rd_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  arcp_pkg::frame_rec_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

### design/arcp_back.sv
// back part: completes a frame record (missing positions) and holds the result
// depends on arcp_pkg; reads from arcp_queue
module arcp_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rec_valid,
  input  arcp_pkg::frame_rec_t  rec,
  output logic                  rec_pop,
  output logic                  empty,
  input  logic                  pop,
  output arcp_pkg::out_item_t   result
);

  logic                 out_valid;
  arcp_pkg::out_item_t  out_reg;
  arcp_pkg::out_item_t  out_next;
  logic [2:0]           st;

  // positions not reached count as zero bytes, which fail the first open check
  always_comb begin
    st = rec.status;
    if (rec.status == arcp_pkg::ST_OK && rec.position != arcp_pkg::POS_LAST) begin
      case (rec.position)
        arcp_pkg::POS_COMMA1: st = arcp_pkg::ST_COMMA1;
        arcp_pkg::POS_COMMA2: st = arcp_pkg::ST_COMMA2;
        default:              st = arcp_pkg::ST_BAD_HEX;
      endcase
    end
    out_next.is_read     = (st == arcp_pkg::ST_BAD_OP) ? 1'b0 : rec.op_is_read;
    out_next.reg_address = rec.address;
    out_next.reg_data    = rec.data;
    out_next.status      = st;
  end

  assign rec_pop = rec_valid && (!out_valid || pop);
  assign empty   = !out_valid;
  assign result  = out_reg;

  always_ff @(posedge clk) begin
    if (rec_pop) out_reg <= out_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### design/ascii_register_command_parser_top.sv
// top level of the ascii register command parser
// depends on arcp_pkg, arcp_front, arcp_queue, arcp_back
//
// usage:
//   characters of a frame "op,AA,DD" enter on char_in, one per transaction,
//   taken when push is high and full is low; frame_end marks the last one.
//   one result per frame leaves on result, valid while empty is low and
//   taken when pop is high.
//   a character is taken every cycle while full is low, so the input rate
//   is one character per clock.
//   the frame record of a taken end character is written into the frame
//   queue, then registered in the output register once that is free.
//   results can leave at one per clock while pop is high and frames wait.
//   full rises only when QUEUE_DEPTH finished frames wait behind a result
//   the receiver has not popped; characters of an open frame then wait too.
//   reset clears the frame state, the queue and the output valid flag; the
//   block is ready in the cycle after rst falls.
module ascii_register_command_parser_top #(
  parameter int QUEUE_DEPTH = arcp_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  arcp_pkg::in_item_t   char_in,
  output logic                 empty,
  input  logic                 pop,
  output arcp_pkg::out_item_t  result
);

  logic                  accept;
  logic                  rec_push;
  arcp_pkg::frame_rec_t  rec_in;
  arcp_pkg::frame_rec_t  rec_out;
  logic                  rec_valid;
  logic                  rec_pop;

  assign accept = push && !full;

  arcp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .char_in  (char_in),
    .rec_push (rec_push),
    .rec      (rec_in)
  );

  arcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (rec_push),
    .wr_data  (rec_in),
    .full     (full),
    .rd_en    (rec_pop),
    .rd_data  (rec_out),
    .rd_valid (rec_valid)
  );

  arcp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec       (rec_out),
    .rec_pop   (rec_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

### bench/tb.sv
// testbench for ascii_register_command_parser_top: directed frames, then random frames
// with random sender idling, receiver stalls and one long receiver hold-off
// depends on arcp_pkg and the rtl of the block
module tb;
  import arcp_pkg::*;

  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_CHARS = 190;
  localparam int DRAIN_CYCLES = 10;

  logic      clk = 1'b0;
  logic      rst;
  logic      push;
  logic      full;
  logic      empty;
  logic      pop;
  in_item_t  char_in;
  out_item_t result;

  ascii_register_command_parser_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .char_in (char_in),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser state mirrored by the predictor
  logic [2:0] frame_pos;
  logic       frame_rd;
  logic [7:0] frame_addr;
  logic [7:0] frame_data;
  logic [2:0] frame_status;
  logic       frame_digit_on;

  out_item_t pending_results[$];
  int        mismatches;
  int        chars_sent;
  int        results_checked;
  int        full_stalls;
  int        status_seen[5];
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_requests;
  int        hold_served;
  int        hold_left;
  int        quiet_cycles;

  typedef struct {
    logic [7:0] c;
    logic       e;
    bit         typed;
    out_item_t  want;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic void clear_frame();
    frame_pos = POS_OP;
    frame_rd = 1'b0;
    frame_addr = 8'h00;
    frame_data = 8'h00;
    frame_status = ST_OK;
    frame_digit_on = 1'b0;
  endfunction

  function automatic logic [3:0] nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    if (frame_status == ST_OK) frame_status = ST_BAD_HEX;
    return 4'h0;
  endfunction

  function automatic void take_char(input logic [7:0] c);
    case (frame_pos)
      POS_OP: begin
        if (c == CH_W_UP || c == CH_W_LO) frame_rd = 1'b0;
        else if (c == CH_R_UP || c == CH_R_LO) frame_rd = 1'b1;
        else frame_status = ST_BAD_OP;
      end
      POS_COMMA1: begin
        if (frame_status == ST_OK && c != CH_COMMA) frame_status = ST_COMMA1;
      end
      POS_ADDR_HI: begin
        frame_digit_on = (frame_status == ST_OK);
        if (frame_digit_on) frame_addr = {nibble(c), 4'h0};
      end
      POS_ADDR_LO: begin
        if (frame_digit_on) frame_addr = frame_addr | {4'h0, nibble(c)};
        frame_digit_on = 1'b0;
      end
      POS_COMMA2: begin
        if (frame_status == ST_OK && c != CH_COMMA) frame_status = ST_COMMA2;
      end
      POS_DATA_HI: begin
        frame_digit_on = (frame_status == ST_OK);
        if (frame_digit_on) frame_data = {nibble(c), 4'h0};
      end
      POS_DATA_LO: begin
        if (frame_digit_on) frame_data = frame_data | {4'h0, nibble(c)};
        frame_digit_on = 1'b0;
      end
      default: begin
      end
    endcase
    if (frame_pos != POS_LAST) frame_pos = frame_pos + 3'd1;
  endfunction

  // returns 1 when the character closes a frame, with the parsed command in cmd
  function automatic bit parse_char(input logic [7:0] c, input logic e, output out_item_t cmd);
    cmd = '0;
    take_char(c);
    if (!e) return 1'b0;
    while (frame_pos != POS_LAST) take_char(8'h00);
    cmd.is_read = (frame_status == ST_BAD_OP) ? 1'b0 : frame_rd;
    cmd.reg_address = frame_addr;
    cmd.reg_data = frame_data;
    cmd.status = frame_status;
    status_seen[frame_status]++;
    clear_frame();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic add_row(input logic [7:0] c, input logic e, input bit typed = 1'b0,
                         input logic rd = 1'b0, input logic [7:0] addr = 8'h00,
                         input logic [7:0] data = 8'h00, input logic [2:0] st = ST_OK);
    plan_row_t row;
    row.c = c;
    row.e = e;
    row.typed = typed;
    row.want.is_read = rd;
    row.want.reg_address = addr;
    row.want.reg_data = data;
    row.want.status = st;
    plan.push_back(row);
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_char(input logic [7:0] c, input logic e, input bit typed = 1'b0,
                           input out_item_t typed_want = '0);
    out_item_t cmd;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    char_in <= {c, e};
    do @(posedge clk); while (full);
    chars_sent++;
    if (parse_char(c, e, cmd)) pending_results.push_back(typed ? typed_want : cmd);
    @(negedge clk);
  endtask

  task automatic send_frame();
    string      hex_chars;
    int         len;
    logic [7:0] c;
    hex_chars = "0123456789ABCDEFabcdef";
    len = ($urandom_range(99) < 75) ? 7 : $urandom_range(10, 1);
    for (int i = 0; i < len; i++) begin
      case (i)
        0: begin
          case ($urandom_range(3))
            0: c = CH_W_UP;
            1: c = CH_W_LO;
            2: c = CH_R_UP;
            default: c = CH_R_LO;
          endcase
        end
        1, 4: c = CH_COMMA;
        2, 3, 5, 6: c = hex_chars[$urandom_range(21)];
        default: c = 8'($urandom_range(255));
      endcase
      if ($urandom_range(99) < 6) c = 8'($urandom_range(255));
      send_char(c, i == len - 1);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int target;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    target = chars_sent + PHASE_CHARS;
    while (chars_sent < target) begin
      if ($urandom_range(99) < 10) send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      else send_frame();
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", result.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (result.is_read !== want.is_read)
          report_mismatch("is_read", result.is_read, want.is_read);
        if (result.reg_address !== want.reg_address)
          report_mismatch("reg_address", result.reg_address, want.reg_address);
        if (result.reg_data !== want.reg_data)
          report_mismatch("reg_data", result.reg_data, want.reg_data);
        if (result.status !== want.status)
          report_mismatch("status", result.status, want.status);
        results_checked++;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (push && full) full_stalls++;
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    char_in = '0;
    mismatches = 0;
    chars_sent = 0;
    results_checked = 0;
    full_stalls = 0;
    status_seen = '{default: 0};
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    quiet_cycles = 0;
    clear_frame();

    add_row("W", 1'b0); add_row(",", 1'b0); add_row("0", 1'b0); add_row("0", 1'b0);
    add_row(",", 1'b0); add_row("0", 1'b0);
    add_row("0", 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, ST_OK);
    // mixed case digits, frame cut short before the last digit
    add_row("r", 1'b0); add_row(",", 1'b0); add_row("F", 1'b0); add_row("f", 1'b0);
    add_row(",", 1'b0); add_row("a", 1'b1);
    add_row(8'h00, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, ST_BAD_OP);
    add_row("R", 1'b1, 1'b1, 1'b1, 8'h00, 8'h00, ST_COMMA1);
    add_row("w", 1'b0); add_row(",", 1'b0); add_row("9", 1'b0);
    add_row("G", 1'b1, 1'b1, 1'b0, 8'h90, 8'h00, ST_BAD_HEX);
    add_row("R", 1'b0); add_row(",", 1'b0); add_row("1", 1'b0); add_row("2", 1'b0);
    add_row(8'hFF, 1'b1, 1'b1, 1'b1, 8'h12, 8'h00, ST_COMMA2);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) send_char(plan[i].c, plan[i].e, plan[i].typed, plan[i].want);

    run_phase(0, 0);
    // receiver holds off while frames keep coming, so the block fills and stalls
    hold_requests++;
    send_idle_pct = 0;
    repeat (40) send_frame();
    run_phase(46, 0);
    run_phase(0, 46);
    run_phase(6, 6);

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d characters sent, %0d commands checked, %0d cycles with input held by full",
             chars_sent, results_checked, full_stalls);
    $display("statuses ok %0d, bad op %0d, no comma1 %0d, no comma2 %0d, bad hex %0d",
             status_seen[ST_OK], status_seen[ST_BAD_OP], status_seen[ST_COMMA1],
             status_seen[ST_COMMA2], status_seen[ST_BAD_HEX]);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
